/* hdl/ple_pkg.sv */
// ple_pkg: shared types, codes and defaults for the positional list engine
// no dependencies; used by ple_ctrl, ple_dp and positional_list_engine
`default_nettype none

package ple_pkg;

  parameter int unsigned DefCapacity  = 16;
  parameter int unsigned DefDataWidth = 32;

  typedef enum logic [2:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_REM_HEAD = 3'd3,
    REQ_REM_TAIL = 3'd4,
    REQ_REM_POS  = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RANGE       = 2'd1,
    ST_REMOVE_FAIL = 2'd2,
    ST_FULL        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_INS = 2'd1,
    OP_REM = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_INS_CHK = 3'd1,
    S_INS_WR  = 3'd2,
    S_REM_RD  = 3'd3,
    S_REM_CAP = 3'd4,
    S_REM_CHK = 3'd5,
    S_REM_WR  = 3'd6,
    S_DONE    = 3'd7
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  position;
    logic [31:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_from_val;
    logic    idx_dec;
    logic    idx_inc;
    logic    cap_removed;
    logic    count_inc;
    logic    count_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_e  dec_op;
    logic more;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/ple_ctrl.sv */
// ple_ctrl: request sequencer and output valid for the positional list engine
// depends on ple_pkg; drives ple_dp through cmd_t, reads sts_t
`default_nettype none

module ple_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ple_pkg::sts_t sts_i,
  output ple_pkg::cmd_t      cmd_o
);
  import ple_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.rd_sel = RD_IDX;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (sts_i.dec_op)
            OP_INS:  state_d = S_INS_CHK;
            OP_REM:  state_d = S_REM_RD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS_CHK: begin
        if (sts_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_INS_WR;
        end else begin
          cmd_o.wr_en       = 1'b1;
          cmd_o.wr_from_val = 1'b1;
          cmd_o.count_inc   = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_INS_CHK;
      end
      S_REM_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_REM_CAP;
      end
      S_REM_CAP: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (sts_i.more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_REM_WR;
        end else begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_REM_CHK;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

/* hdl/ple_dp.sv */
// ple_dp: request decode, entry memory, index and count registers, result register
// depends on ple_pkg; controlled by ple_ctrl through cmd_t
`default_nettype none

module ple_dp #(
  parameter int unsigned CAPACITY   = ple_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = ple_pkg::DefDataWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ple_pkg::req_t in_req_i,
  input  wire ple_pkg::cmd_t cmd_i,
  output ple_pkg::sts_t      sts_o,
  output ple_pkg::rsp_t      rsp_o
);
  import ple_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned W  = (CW > 5) ? CW : 5;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q, val_q, removed_q, wdata;
  logic [CW-1:0]         count_q, idx_q, at_q, idx_d, rd_idx;
  op_e                   op_q, dec_op;
  status_e               status_q, dec_status;
  logic [W-1:0]          pos_w, cnt_w, at_w;
  logic [63:0]           val_ext, rem_ext, cnt_ext;
  rsp_t                  rsp_q;

  // request decode against the current count
  always_comb begin
    pos_w      = W'(in_req_i.position);
    cnt_w      = W'(count_q);
    at_w       = '0;
    dec_op     = OP_NOP;
    dec_status = ST_OK;
    case (req_type_e'(in_req_i.req_type))
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (in_req_i.req_type == REQ_INS_TAIL) begin
          at_w = cnt_w;
        end else if (in_req_i.req_type == REQ_INS_POS) begin
          at_w = pos_w;
        end
        if (at_w > cnt_w) begin
          dec_status = ST_RANGE;
        end else if (count_q == CW'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else begin
          dec_op = OP_INS;
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (in_req_i.req_type == REQ_REM_TAIL) begin
          at_w = cnt_w - W'(1);
        end else if (in_req_i.req_type == REQ_REM_POS) begin
          at_w = pos_w;
        end
        if ((count_q == '0) || (at_w >= cnt_w)) begin
          dec_status = ST_REMOVE_FAIL;
        end else begin
          dec_op = OP_REM;
        end
      end
      default: begin
        dec_op     = OP_NOP;
        dec_status = ST_OK;
      end
    endcase
  end

  assign sts_o.dec_op = dec_op;
  assign sts_o.more   = (op_q == OP_INS) ? (idx_q > at_q)
                                         : ((idx_q + CW'(1)) < count_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (dec_op == OP_INS) ? count_q : at_w[CW-1:0];
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      op_q     <= OP_NOP;
      idx_q    <= '0;
      at_q     <= '0;
      status_q <= ST_OK;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.load) begin
        op_q     <= dec_op;
        at_q     <= at_w[CW-1:0];
        status_q <= dec_status;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign val_ext = 64'(in_req_i.entry_value);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q     <= val_ext[DATA_WIDTH-1:0];
      removed_q <= '0;
    end else if (cmd_i.cap_removed) begin
      removed_q <= rdata_q;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PREV: rd_idx = idx_q - CW'(1);
      RD_NEXT: rd_idx = idx_q + CW'(1);
      default: rd_idx = idx_q;
    endcase
  end

  assign wdata = cmd_i.wr_from_val ? val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[idx_q[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_idx[AW-1:0]];
    end
  end

  assign rem_ext = 64'(removed_q);
  assign cnt_ext = 64'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q.removed_value <= rem_ext[31:0];
      rsp_q.status        <= status_q;
      rsp_q.entry_count   <= cnt_ext[4:0];
    end
  end

  assign rsp_o = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> (idx_q < CW'(CAPACITY)))
    else $error("memory write outside the list");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_inc |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count");

endmodule

`default_nettype wire

/* hdl/positional_list_engine.sv */
// positional_list_engine: bounded ordered list of handles, top level
// depends on ple_pkg, ple_ctrl and ple_dp
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o   in_req_i  (ple_pkg::req_t)
//   out      output     out_valid_o / out_ready_i out_rsp_o (ple_pkg::rsp_t)
//
// one request at a time; a memory shift moves one entry with a read step then a write step
// insert at position p shifts entries p to count - 1 up by one place, remove at p
// shifts the entries above p down by one place; refused or unused requests shift nothing
// reset empties the list at once; entries are not cleared
// a result waiting in the output register stalls only the completion step
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY   = ple_pkg::DefCapacity,
  parameter int unsigned DATA_WIDTH = ple_pkg::DefDataWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ple_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ple_pkg::rsp_t      out_rsp_o
);
  import ple_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ple_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire

/* tb/positional_list_engine_test.sv */
// positional_list_engine_test: self-checking bench for the positional list engine
// drives random and directed list requests, predicts each response from a shadow list
// depends on ple_pkg and positional_list_engine
module positional_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int unsigned Capacity = DefCapacity;
  localparam logic [2:0] ReqSpareA = 3'd6;
  localparam logic [2:0] ReqSpareB = 3'd7;
  localparam int unsigned RandPerPhase = 433;

  typedef struct {
    req_t        req;
    bit          drain;
    int unsigned phase;
  } pending_req_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  pending_req_t req_q[$];
  logic [31:0]  shadow_list[$];
  rsp_t         due_rsps[$];
  int unsigned  send_idle_pct = 27;
  int unsigned  recv_idle_pct = 66;
  int unsigned  mismatches    = 0;

  positional_list_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void queue_req(logic [2:0] kind, int unsigned pos, logic [31:0] value,
                                    bit drain, int unsigned phase);
    pending_req_t p;
    p.req.req_type    = kind;
    p.req.position    = pos[4:0];
    p.req.entry_value = value;
    p.drain           = drain;
    p.phase           = phase;
    req_q.push_back(p);
  endfunction

  function automatic void update_shadow_list(req_t r);
    rsp_t        rsp;
    int unsigned at;
    int unsigned n;
    rsp = '0;
    n   = shadow_list.size();
    case (r.req_type)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (r.req_type == REQ_INS_HEAD) at = 0;
        else if (r.req_type == REQ_INS_TAIL) at = n;
        else at = 32'(r.position);
        // range check wins over full
        if (at > n) rsp.status = ST_RANGE;
        else if (n >= Capacity) rsp.status = ST_FULL;
        else shadow_list.insert(at, r.entry_value);
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (r.req_type == REQ_REM_HEAD) at = 0;
        else if (r.req_type == REQ_REM_TAIL) at = (n == 0) ? 0 : n - 1;
        else at = 32'(r.position);
        if (at >= n) begin
          rsp.status = ST_REMOVE_FAIL;
        end else begin
          rsp.removed_value = shadow_list[at];
          shadow_list.delete(at);
        end
      end
      default: ;
    endcase
    rsp.entry_count = 5'(shadow_list.size());
    due_rsps.push_back(rsp);
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    req_t next_req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      next_valid = in_valid_i;
      next_req   = in_req_i;
      if (in_valid_i && in_ready_o) begin
        update_shadow_list(in_req_i);
        next_valid = 1'b0;
      end
      if (!next_valid && req_q.size() != 0) begin
        case (req_q[0].phase)
          0: begin send_idle_pct = 27; recv_idle_pct = 66; end
          1: begin send_idle_pct = 66; recv_idle_pct = 27; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        if (!(req_q[0].drain && due_rsps.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          next_req   = req_q[0].req;
          next_valid = 1'b1;
          void'(req_q.pop_front());
        end
      end
      in_valid_i <= next_valid;
      in_req_i   <= next_req;
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_rsps.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual %h", $time, out_rsp_o);
          mismatches++;
        end else begin
          want = due_rsps.pop_front();
          report_field("removed_value", want.removed_value, out_rsp_o.removed_value);
          report_field("status", 32'(want.status), 32'(out_rsp_o.status));
          report_field("entry_count", 32'(want.entry_count), 32'(out_rsp_o.entry_count));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned ph;
    int unsigned n;
    int unsigned roll;
    int unsigned pos;
    int unsigned pick;
    bit          ins_bias;
    logic [2:0]  kind;
    logic [31:0] value;

    // empty list corner cases
    queue_req(REQ_REM_HEAD, 0, 32'h0, 1'b0, 0);
    queue_req(REQ_REM_TAIL, 5, '1, 1'b0, 0);
    queue_req(REQ_REM_POS, 0, 32'h0, 1'b0, 0);
    queue_req(REQ_INS_POS, 1, '1, 1'b0, 0);
    // fill to capacity with every insert kind
    for (i = 0; i < Capacity; i++) begin
      if (i % 3 == 0) kind = REQ_INS_HEAD;
      else if (i % 3 == 1) kind = REQ_INS_TAIL;
      else kind = REQ_INS_POS;
      value = (i == 0) ? '1 : (i == 1) ? 32'h0 : $urandom;
      queue_req(kind, (i % 2) ? i : i / 2, value, 1'b0, 0);
    end
    // full list
    queue_req(REQ_INS_HEAD, 0, 32'h1234_5678, 1'b0, 0);
    queue_req(REQ_INS_POS, 17, 32'h5a5a_5a5a, 1'b0, 0);
    queue_req(REQ_INS_POS, 16, 32'ha5a5_a5a5, 1'b0, 0);
    queue_req(REQ_REM_POS, 16, 32'h0, 1'b0, 0);
    queue_req(REQ_REM_POS, 15, 32'h0, 1'b0, 0);
    queue_req(REQ_REM_POS, 0, 32'h0, 1'b0, 0);
    queue_req(ReqSpareA, 31, '1, 1'b0, 0);
    queue_req(ReqSpareB, 3, 32'h0, 1'b0, 0);
    queue_req(REQ_REM_TAIL, 31, 32'h0, 1'b0, 0);
    queue_req(REQ_REM_HEAD, 0, 32'h0, 1'b0, 0);

    // random bursts alternate between filling and draining the list
    ins_bias = 1'b0;
    for (ph = 0; ph < 3; ph++) begin
      for (n = 0; n < RandPerPhase; n++) begin
        if (n % 40 == 0) ins_bias = ~ins_bias;
        roll = $urandom_range(99);
        if (roll < 5) kind = 3'($urandom_range(6, 7));
        else if (roll < (ins_bias ? 80 : 25)) kind = 3'($urandom_range(0, 2));
        else kind = 3'($urandom_range(3, 5));
        pos  = ($urandom_range(99) < 85) ? $urandom_range(0, 17) : $urandom_range(0, 31);
        pick = $urandom_range(19);
        value = (pick == 0) ? 32'h0 : (pick == 1) ? '1 : $urandom;
        queue_req(kind, pos, value, (n == 0) || ($urandom_range(99) == 0), ph);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (req_q.size() == 0 && !in_valid_i && due_rsps.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && due_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_dp.sv
hdl/positional_list_engine.sv
tb/positional_list_engine_test.sv
